// ===== rtl/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;

	localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [1:0] OP_POP_BACK   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// What one cell shows its neighbors.
	typedef struct packed {
		logic              occ;
		logic [DATA_W-1:0] data;
	} cell_t;

	// One operation, already checked against full and empty.
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/deq_cell.sv =====
`default_nettype none

module deq_cell
	import deq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic [DATA_W-1:0] push_value,
	input  wire cell_t             left,
	input  wire cell_t             right,
	output cell_t                  cur
);

	logic              occ_q;
	logic [DATA_W-1:0] data_q;

	assign cur.occ  = occ_q;
	assign cur.data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.push_front) begin
			occ_q <= left.occ;
		end else if (cmd.push_back) begin
			if (!occ_q && left.occ) begin
				occ_q <= 1'b1;
			end
		end else if (cmd.pop_front) begin
			occ_q <= right.occ;
		end else if (cmd.pop_back) begin
			if (occ_q && !right.occ) begin
				occ_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			data_q <= left.data;
		end else if (cmd.push_back && !occ_q && left.occ) begin
			data_q <= push_value;
		end else if (cmd.pop_front) begin
			data_q <= right.data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
`default_nettype none

// The result strobe done comes in the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, since the cells that change
// shift or load in the same edge that takes the item.
// Reset: arst_n empties the queue at once (occupancy bits and count cleared).
// The receiver cannot stall; each result is shown for exactly one cycle.
module double_ended_queue
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               opcode,
	input  wire logic signed [DATA_W-1:0] push_value,
	output logic                          done,
	output logic [1:0]                    status,
	output logic signed [DATA_W-1:0]      front_value,
	output logic signed [DATA_W-1:0]      back_value,
	output logic                          is_empty,
	output logic [CW-1:0]                 element_count
);

	cell_t             cells [DEPTH];
	cmd_t              cmd;
	logic              accept;
	logic              full;
	logic              empty;
	logic [1:0]        status_d;
	logic [1:0]        status_q;
	logic              done_q;
	logic [CW-1:0]     count_q;
	logic [DATA_W-1:0] back_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = cells[DEPTH-1].occ;
	assign empty  = !cells[0].occ;

	always_comb begin
		cmd      = '0;
		status_d = ST_OK;
		case (opcode)
			OP_PUSH_FRONT: begin
				if (full) status_d = ST_FULL;
				else cmd.push_front = accept;
			end
			OP_PUSH_BACK: begin
				if (full) status_d = ST_FULL;
				else cmd.push_back = accept;
			end
			OP_POP_FRONT: begin
				if (empty) status_d = ST_EMPTY;
				else cmd.pop_front = accept;
			end
			OP_POP_BACK: begin
				if (empty) status_d = ST_EMPTY;
				else cmd.pop_back = accept;
			end
			default: status_d = ST_OK;
		endcase
	end

	// The head cell sees an occupied left neighbor carrying the pushed value,
	// and the tail cell sees an empty right neighbor.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_t left_in;
		cell_t right_in;
		if (i == 0) begin : g_head
			assign left_in = '{occ: 1'b1, data: push_value};
		end else begin : g_left
			assign left_in = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_in = '{occ: 1'b0, data: '0};
		end else begin : g_right
			assign right_in = cells[i+1];
		end
		deq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.push_value(push_value),
			.left      (left_in),
			.right     (right_in),
			.cur       (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			status_q <= ST_OK;
			count_q  <= '0;
		end else begin
			done_q <= accept;
			if (accept) begin
				status_q <= status_d;
			end
			if (cmd.push_front || cmd.push_back) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop_front || cmd.pop_back) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// The back element is the last occupied cell; at most one cell matches.
	always_comb begin
		back_d = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cells[i].occ && (i == DEPTH - 1 || !cells[(i + 1) % DEPTH].occ)) begin
				back_d = back_d | cells[i].data;
			end
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign is_empty      = empty;
	assign element_count = count_q;
	assign front_value   = empty ? '0 : cells[0].data;
	assign back_value    = back_d;

endmodule

`default_nettype wire

// ===== rtl/deq_checker.sv =====
`default_nettype none

module deq_checker
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic                     done,
	input wire logic [1:0]               status,
	input wire logic signed [DATA_W-1:0] front_value,
	input wire logic signed [DATA_W-1:0] back_value,
	input wire logic                     is_empty,
	input wire logic [CW-1:0]            element_count
);

	// Every taken item gives exactly one result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("item taken but no result strobe");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result strobe without a taken item");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (element_count == '0)))
		else $error("empty flag disagrees with element count");

	a_empty_values: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_empty |-> front_value == '0 && back_value == '0)
		else $error("empty queue shows nonzero values");

	// A rejected operation leaves the count as the previous result showed it.
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(done) && (status == ST_FULL || status == ST_EMPTY)
			|-> element_count == $past(element_count))
		else $error("rejected operation changed the count");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.front_value  (front_value),
	.back_value   (back_value),
	.is_empty     (is_empty),
	.element_count(element_count)
);

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
	import deq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int AW         = $clog2(DEPTH);
	localparam int CW         = $clog2(DEPTH + 1);
	localparam int RAND_ITEMS = 1025;
	localparam int MAX_GAP    = 17;
	localparam int LIMIT      = 200000;
	localparam int MAX_SHOWN  = 10;

	// What the block reports after one operation.
	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] front;
		logic signed [DATA_W-1:0] back;
		logic                     empty;
		logic [CW-1:0]            count;
	} deq_view_t;

	typedef struct {
		logic [1:0]        op;
		logic [DATA_W-1:0] value;
		bit                typed;
		deq_view_t         view;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] opcode = OP_PUSH_FRONT;
	logic signed [DATA_W-1:0] push_value = '0;
	logic busy;
	logic done;
	logic [1:0] status;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic is_empty;
	logic [CW-1:0] element_count;

	// Shadow copy of the deque contents.
	logic [DATA_W-1:0] slot_mem [DEPTH];
	logic [AW-1:0] head_idx = '0;
	logic [CW-1:0] fill_count = '0;

	deq_view_t expected_views [$];
	stim_row_t directed_rows [$];
	int errors = 0;
	int cycles = 0;

	double_ended_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.push_value(push_value),
		.done(done),
		.status(status),
		.front_value(front_value),
		.back_value(back_value),
		.is_empty(is_empty),
		.element_count(element_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Applies one operation to the shadow deque and returns the view after it.
	function automatic deq_view_t deque_apply(logic [1:0] op, logic [DATA_W-1:0] value);
		deq_view_t v;
		logic [AW-1:0] idx;
		v = '0;
		v.status = ST_OK;
		if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
			if (fill_count == DEPTH) begin
				v.status = ST_FULL;
			end else if (op == OP_PUSH_FRONT) begin
				head_idx = head_idx - 1'b1;
				slot_mem[head_idx] = value;
				fill_count = fill_count + 1'b1;
			end else begin
				idx = head_idx + fill_count[AW-1:0];
				slot_mem[idx] = value;
				fill_count = fill_count + 1'b1;
			end
		end else begin
			if (fill_count == 0) begin
				v.status = ST_EMPTY;
			end else if (op == OP_POP_FRONT) begin
				head_idx = head_idx + 1'b1;
				fill_count = fill_count - 1'b1;
			end else begin
				fill_count = fill_count - 1'b1;
			end
		end
		if (fill_count != 0) begin
			idx = head_idx + fill_count[AW-1:0] - 1'b1;
			v.front = slot_mem[head_idx];
			v.back = slot_mem[idx];
		end
		v.empty = (fill_count == 0);
		v.count = fill_count;
		return v;
	endfunction

	task automatic add_row(logic [1:0] op, logic [DATA_W-1:0] value, bit typed, deq_view_t view);
		stim_row_t r;
		r.op = op;
		r.value = value;
		r.typed = typed;
		r.view = view;
		directed_rows.push_back(r);
	endtask

	// Offers one item, waits until it is taken, then idles for the given gap.
	task automatic send_item(logic [1:0] op, logic [DATA_W-1:0] value, bit typed,
			deq_view_t view, int gap);
		deq_view_t predicted;
		@(negedge clk);
		start <= 1'b1;
		opcode <= op;
		push_value <= value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = deque_apply(op, value);
		expected_views.push_back(typed ? view : predicted);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		deq_view_t got;
		deq_view_t want;
		if (arst_n && done) begin
			got = '{status, front_value, back_value, is_empty, element_count};
			if (expected_views.size() == 0) begin
				errors <= errors + 1;
				if (errors < MAX_SHOWN)
					$display("unexpected result: status %0d front %0d back %0d empty %0b count %0d",
						got.status, got.front, got.back, got.empty, got.count);
			end else begin
				want = expected_views.pop_front();
				if (got !== want) begin
					errors <= errors + 1;
					if (errors < MAX_SHOWN) begin
						$display("mismatch: expected status %0d front %0d back %0d empty %0b count %0d",
							want.status, want.front, want.back, want.empty, want.count);
						$display("          got status %0d front %0d back %0d empty %0b count %0d",
							got.status, got.front, got.back, got.empty, got.count);
					end
				end
			end
		end
	end

	initial begin
		logic [1:0] op;
		logic [DATA_W-1:0] value;
		int seg_left;
		int push_pct;
		int gap_mode;
		int gap;
		seg_left = 0;
		push_pct = 50;
		gap_mode = 0;

		add_row(OP_POP_FRONT, 32'h1234_5678, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 1'b1, 5'd0});
		add_row(OP_POP_BACK, 32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 1'b1, 5'd0});
		add_row(OP_PUSH_BACK, 32'h7FFF_FFFF, 1'b1,
			'{ST_OK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 5'd1});
		add_row(OP_PUSH_FRONT, 32'h8000_0000, 1'b1,
			'{ST_OK, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 5'd2});
		add_row(OP_POP_BACK, 32'h0, 1'b1, '{ST_OK, 32'h8000_0000, 32'h8000_0000, 1'b0, 5'd1});
		add_row(OP_POP_FRONT, 32'h0, 1'b1, '{ST_OK, 32'sd0, 32'sd0, 1'b1, 5'd0});
		// The front pointer is back at slot zero, so this push wraps below it.
		add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0);
		for (int i = 0; i < DEPTH - 1; i++)
			add_row(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, $urandom, 1'b0, '0);
		// The deque is full now: both pushes must be refused.
		add_row(OP_PUSH_BACK, 32'h0, 1'b0, '0);
		add_row(OP_PUSH_FRONT, 32'h5555_5555, 1'b0, '0);
		add_row(OP_POP_BACK, 32'hAAAA_AAAA, 1'b0, '0);

		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
				directed_rows[i].view, $urandom_range(0, MAX_GAP));

		for (int n = 0; n < RAND_ITEMS; n++) begin
			// Segments lean toward pushes or pops, or balance the two, so that the deque keeps
			// running into its full and empty limits.
			if (seg_left == 0) begin
				seg_left = $urandom_range(30, 120);
				case ($urandom_range(0, 2))
					0: push_pct = 25;
					1: push_pct = 50;
					default: push_pct = 80;
				endcase
				gap_mode = $urandom_range(0, 2);
			end
			seg_left--;
			if (n == RAND_ITEMS / 2)
				wait_drained();
			if ($urandom_range(0, 99) < push_pct)
				op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
			else
				op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
			case ($urandom_range(0, 7))
				0: value = 32'h8000_0000;
				1: value = 32'h7FFF_FFFF;
				2: value = 32'h0;
				3: value = 32'hFFFF_FFFF;
				default: value = $urandom;
			endcase
			case (gap_mode)
				0: gap = 0;
				1: gap = $urandom_range(0, MAX_GAP);
				default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
			endcase
			send_item(op, value, 1'b0, '0, gap);
		end

		wait_drained();
		repeat (5)
			@(posedge clk);
		if (errors == 0 && expected_views.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
